FILE: rtl/core/chbc_pkg.sv
`default_nettype none

package chbc_pkg;

    // Key storage: three 64-bit registers, up to 24 key bytes
    localparam int KEY_LEN_DEF   = 20;
    localparam int KEY_BYTES_MAX = 24;
    localparam int KEY_W         = KEY_BYTES_MAX * 8;
    localparam int IDX_W         = 5;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [IDX_W-1:0]      t_key_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    // Register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_KEY_LO  = 2'd0,
        REG_KEY_MID = 2'd1,
        REG_KEY_HI  = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_DECRYPT = 1'b0,
        OP_ENCRYPT = 1'b1
    } t_op;

endpackage

`default_nettype wire

FILE: rtl/core/chained_header_byte_cipher_core.sv
`default_nettype none

// Chained header byte cipher. Each accepted word carries one header byte and a
// direction (i_op: 1 encrypt, 0 decrypt) and yields exactly one result byte, in
// order. Encrypt gives (byte xor key[i]) + previous ciphertext mod 256; decrypt
// gives (byte - previous ciphertext) xor key[i]. Each direction keeps its own
// key index, wrapping at KEY_LEN, and its own chain byte; both clear on reset.
// The key is loaded through the APB port as three 64-bit registers at byte
// addresses 0, 8 and 16, key byte 0 in bits 7:0 of the first. Load the key only
// while no word is in flight. Throughput is one byte per cycle unless the output
// stalls. o_out_valid rises the cycle after acceptance, via one result register.
module chained_header_byte_cipher_core
    import chbc_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [7:0]            i_data_byte,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [7:0]            o_result_byte,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg_word  r_key_lo;
    t_cfg_word  r_key_mid;
    t_cfg_word  r_key_hi;
    t_key       key;
    t_reg_idx   reg_idx;
    logic       cfg_wr;
    logic       accept;
    logic       enc_step;
    logic       dec_step;
    logic [7:0] enc_byte;
    logic [7:0] dec_byte;
    logic       r_out_valid;
    logic [7:0] r_result;
    logic [7:0] n_result;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_mid <= '0;
            r_key_hi  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_KEY_LO:  r_key_lo  <= pwdata;
                REG_KEY_MID: r_key_mid <= pwdata;
                REG_KEY_HI:  r_key_hi  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_LO:  prdata = r_key_lo;
            REG_KEY_MID: prdata = r_key_mid;
            REG_KEY_HI:  prdata = r_key_hi;
            default:     prdata = '0;
        endcase
    end

    assign key = {r_key_hi, r_key_mid, r_key_lo};

    // take a new word whenever the result register is free or being emptied
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign enc_step   = accept && (t_op'(i_op) == OP_ENCRYPT);
    assign dec_step   = accept && (t_op'(i_op) == OP_DECRYPT);

    chbc_lane #(
        .KEY_LEN (KEY_LEN),
        .ENCRYPT (1'b1)
    ) u_enc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (key),
        .i_step        (enc_step),
        .i_data_byte   (i_data_byte),
        .o_result_byte (enc_byte)
    );

    chbc_lane #(
        .KEY_LEN (KEY_LEN),
        .ENCRYPT (1'b0)
    ) u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (key),
        .i_step        (dec_step),
        .i_data_byte   (i_data_byte),
        .o_result_byte (dec_byte)
    );

    assign n_result = (t_op'(i_op) == OP_ENCRYPT) ? enc_byte : dec_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while the output is stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_result;

endmodule

`default_nettype wire

FILE: rtl/core/chbc_lane.sv
`default_nettype none

module chbc_lane
    import chbc_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEF,
    parameter bit ENCRYPT = 1'b0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_key       i_key,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    output logic      [7:0] o_result_byte
);

    localparam t_key_idx LAST_IDX = IDX_W'(KEY_LEN - 1);
    localparam t_key_idx LEN_IDX  = IDX_W'(KEY_LEN);

    t_key_idx   r_key_index;
    t_key_idx   n_key_index;
    t_key_idx   use_idx;
    logic [7:0] r_chain;
    logic [7:0] n_chain;
    logic [7:0] key_byte;

    always_comb begin
        // an index at or past the key length reads as index zero
        use_idx  = (KEY_LEN < 32 && r_key_index >= LEN_IDX) ? '0 : r_key_index;
        key_byte = i_key[{use_idx, 3'b000} +: 8];

        if (ENCRYPT) begin
            o_result_byte = (i_data_byte ^ key_byte) + r_chain;
            n_chain       = o_result_byte;
        end else begin
            o_result_byte = (i_data_byte - r_chain) ^ key_byte;
            n_chain       = i_data_byte;
        end

        n_key_index = (use_idx == LAST_IDX) ? '0 : use_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_index <= '0;
            r_chain     <= '0;
        end else if (i_step) begin
            r_key_index <= n_key_index;
            r_chain     <= n_chain;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_chained_header_byte_cipher_core.sv
module tb_chained_header_byte_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import chbc_pkg::*;

    localparam int KEY_LEN     = KEY_LEN_DEF;
    localparam int QUIET_LIMIT = 2000;

    // Keeps its own copy of the key and both chains, and queues the byte each word should give
    class chain_cipher_sb;
        t_cfg_word  key_regs[3];
        t_key_idx   enc_idx;
        t_key_idx   dec_idx;
        logic [7:0] enc_chain;
        logic [7:0] dec_chain;
        logic [7:0] expected_bytes[$];
        int         mismatches;

        function new();
            key_regs   = '{default: '0};
            enc_idx    = '0;
            dec_idx    = '0;
            enc_chain  = '0;
            dec_chain  = '0;
            mismatches = 0;
        endfunction

        function void set_key_reg(t_reg_idx r, t_cfg_word v);
            if (r != REG_NONE) begin
                key_regs[int'(r)] = v;
            end
        endfunction

        function logic [7:0] key_byte(t_key_idx idx);
            t_key key;
            key = {key_regs[2], key_regs[1], key_regs[0]};
            if (idx >= KEY_LEN) begin
                idx = '0;
            end
            return key[idx*8 +: 8];
        endfunction

        function t_key_idx step_idx(t_key_idx idx);
            if (idx >= KEY_LEN) begin
                idx = '0;
            end
            idx = idx + 1'b1;
            if (idx >= KEY_LEN) begin
                idx = '0;
            end
            return idx;
        endfunction

        function void note_word(t_op op, logic [7:0] b);
            logic [7:0] r;
            if (op == OP_ENCRYPT) begin
                r = (b ^ key_byte(enc_idx)) + enc_chain;
                enc_chain = r;
                enc_idx = step_idx(enc_idx);
            end else begin
                r = (b - dec_chain) ^ key_byte(dec_idx);
                dec_chain = b;
                dec_idx = step_idx(dec_idx);
            end
            expected_bytes.push_back(r);
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                $error("result_byte: expected none, actual %02h", got);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                $error("result_byte: expected %02h, actual %02h", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_op          = 1'b0;
    logic [7:0]            i_data_byte   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [7:0]            o_result_byte;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    chain_cipher_sb sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    chained_header_byte_cipher_core #(
        .KEY_LEN(KEY_LEN)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_byte(o_result_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: a requested hold-off wins over random stalling
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_result_byte);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic cfg_write(input t_reg_idx r, input t_cfg_word v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_key_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_key(input t_cfg_word lo, input t_cfg_word mid, input t_cfg_word hi);
        cfg_write(REG_KEY_LO, lo);
        cfg_write(REG_KEY_MID, mid);
        cfg_write(REG_KEY_HI, hi);
        // no register behind this address: the key must stay as it is
        cfg_write(REG_NONE, {$urandom, $urandom});
    endtask

    task automatic send_word(input t_op op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(op, b);
    endtask

    // Drop valid and hold until every expected byte is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Runs of one direction with occasional switches, so both indices wrap often
    task automatic send_random(input int count);
        t_op        op;
        logic [7:0] b;
        op = t_op'($urandom_range(1));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(7) == 0) begin
                op = (op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
            end
            case ($urandom_range(15))
                0:       b = 8'h00;
                1:       b = 8'hff;
                default: b = 8'($urandom);
            endcase
            send_word(op, b);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 16;
        recv_stall_pct = 52;
        load_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'hdead_beef_a5c3_3c5a);

        // extremes in both directions, then one full encrypt key cycle and a wrap
        send_word(OP_DECRYPT, 8'h00);
        send_word(OP_DECRYPT, 8'hff);
        send_word(OP_DECRYPT, 8'h80);
        send_word(OP_DECRYPT, 8'h7f);
        for (int n = 0; n < KEY_LEN + 1; n++) begin
            send_word(OP_ENCRYPT, (n == 0) ? 8'h00 : (n == 1) ? 8'hff : 8'(n * 37));
        end
        drain();

        load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        send_random(300);
        // long receiver hold-off while words keep coming, so the core backs up
        hold_left = 80;
        send_random(310);
        drain();

        send_idle_pct  = 52;
        recv_stall_pct = 16;
        load_key('1, '1, '1);
        send_random(610);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_key('0, '0, {$urandom, $urandom});
        send_random(300);
        drain();
        load_key({$urandom, $urandom}, {$urandom, $urandom}, '0);
        send_random(310);
        drain();

        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: chained_header_byte_cipher_core.f
rtl/core/chbc_pkg.sv
rtl/core/chbc_lane.sv
rtl/core/chained_header_byte_cipher_core.sv
tb/tb_chained_header_byte_cipher_core.sv
